@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent check forms for the utf-8 decoder rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is low
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// next-cycle implication, off while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`endif

@@ rtl/u8d_pkg.sv @@
// ----------------------------------------------------------------------------
// u8d_pkg
// widths, status codes and result type of the utf-8 stream decoder
// ----------------------------------------------------------------------------
`default_nettype none

package u8d_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 21;
  localparam int CNT_W  = 3;
  localparam int ST_W   = 3;
  localparam int LEFT_W = 2;

  // status codes
  localparam logic [ST_W-1:0] ST_VALID      = 3'd0;
  localparam logic [ST_W-1:0] ST_INCOMPLETE = 3'd1;
  localparam logic [ST_W-1:0] ST_BAD_LEAD   = 3'd2;
  localparam logic [ST_W-1:0] ST_SURROGATE  = 3'd3;
  localparam logic [ST_W-1:0] ST_OVERLONG   = 3'd4;
  localparam logic [ST_W-1:0] ST_ABOVE      = 3'd5;

  // code point limits
  localparam logic [CP_W-1:0] CP_SURR_LO  = 21'h00D800;
  localparam logic [CP_W-1:0] CP_SURR_HI  = 21'h00DFFF;
  localparam logic [CP_W-1:0] CP_MIN_2B   = 21'h000080;
  localparam logic [CP_W-1:0] CP_MIN_3B   = 21'h000800;
  localparam logic [CP_W-1:0] CP_MIN_4B   = 21'h010000;
  localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;

  // one decoded word
  typedef struct packed {
    logic [CP_W-1:0]  scalar;
    logic [CNT_W-1:0] byte_count;
    logic [ST_W-1:0]  status;
    logic             null_char;
  } u8d_result_t;

  // status of a completed sequence; surrogate first, then overlong, then range
  function automatic logic [ST_W-1:0] classify(input logic [CP_W-1:0] cp,
                                               input logic [CNT_W-1:0] len);
    logic [ST_W-1:0] st;
    st = ST_VALID;
    if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) st = ST_SURROGATE;
    else if (cp < CP_MIN_2B && len > 3'd1) st = ST_OVERLONG;
    else if (cp < CP_MIN_3B && len > 3'd2) st = ST_OVERLONG;
    else if (cp < CP_MIN_4B && len > 3'd3) st = ST_OVERLONG;
    else if (cp > CP_MAX) st = ST_ABOVE;
    return st;
  endfunction

endpackage

`default_nettype wire

@@ rtl/u8d_in_stage.sv @@
// ----------------------------------------------------------------------------
// u8d_in_stage
// input register: holds one incoming word until the decode step takes it
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_in_stage (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [u8d_pkg::BYTE_W-1:0] in_data_byte,
  input  wire logic                      in_end_of_input,
  input  wire logic                      advance,
  output logic                           item_valid,
  output logic [u8d_pkg::BYTE_W-1:0]     item_byte,
  output logic                           item_last
);
  import u8d_pkg::*;

  logic              valid_r;
  logic [BYTE_W-1:0] byte_r;
  logic              last_r;

  // room when empty or when the held word moves on this cycle
  assign in_ready = !valid_r || advance;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_data_byte;
      last_r <= in_end_of_input;
    end
  end

  assign item_valid = valid_r;
  assign item_byte  = byte_r;
  assign item_last  = last_r;

endmodule

`default_nettype wire

@@ rtl/u8d_core.sv @@
// ----------------------------------------------------------------------------
// u8d_core
// sequence state and single-pass decode of one byte into an optional result
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module u8d_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       item_valid,
  input  wire logic                       advance,
  input  wire logic [u8d_pkg::BYTE_W-1:0] item_byte,
  input  wire logic                       item_last,
  output logic                            res_valid,
  output u8d_pkg::u8d_result_t            res
);
  import u8d_pkg::*;

  logic [CP_W-1:0]   acc_r,  acc_nxt;
  logic [LEFT_W-1:0] left_r, left_nxt;
  logic [CNT_W-1:0]  len_r,  len_nxt;

  logic [CP_W-1:0]   acc_cont;
  logic [LEFT_W-1:0] left_dec;
  logic              emit;
  logic [CP_W-1:0]   cp;
  logic [CNT_W-1:0]  cnt;
  logic [ST_W-1:0]   st;

  assign acc_cont = {acc_r[CP_W-7:0], item_byte[5:0]};
  assign left_dec = left_r - 2'd1;

  // decode one byte against the open sequence
  always_comb begin
    acc_nxt  = acc_r;
    left_nxt = left_r;
    len_nxt  = len_r;
    emit     = 1'b0;
    cp       = '0;
    cnt      = 3'd1;
    st       = ST_VALID;
    if (left_r == 2'd0) begin
      if (item_byte < 8'h80) begin
        emit = 1'b1;
        cp   = {13'd0, item_byte};
      end else if (item_byte >= 8'hC0 && item_byte < 8'hE0) begin
        acc_nxt  = {16'd0, item_byte[4:0]};
        len_nxt  = 3'd2;
        left_nxt = 2'd1;
      end else if (item_byte >= 8'hE0 && item_byte < 8'hF0) begin
        acc_nxt  = {17'd0, item_byte[3:0]};
        len_nxt  = 3'd3;
        left_nxt = 2'd2;
      end else if (item_byte >= 8'hF0 && item_byte < 8'hF8) begin
        acc_nxt  = {18'd0, item_byte[2:0]};
        len_nxt  = 3'd4;
        left_nxt = 2'd3;
      end else begin
        emit = 1'b1;
        st   = ST_BAD_LEAD;
      end
      // end mark right after a multi-byte lead
      if (!emit && item_last) begin
        emit = 1'b1;
        st   = ST_INCOMPLETE;
      end
    end else begin
      acc_nxt  = acc_cont;
      left_nxt = left_dec;
      if (left_dec == 2'd0) begin
        emit = 1'b1;
        cp   = acc_cont;
        cnt  = len_r;
        st   = classify(acc_cont, len_r);
      end else if (item_last) begin
        emit = 1'b1;
        cnt  = len_r - {1'b0, left_dec};
        st   = ST_INCOMPLETE;
      end
    end
    // any result closes the sequence
    if (emit) begin
      acc_nxt  = '0;
      left_nxt = 2'd0;
      len_nxt  = 3'd0;
    end
  end

  // result word
  always_comb begin
    res_valid      = item_valid && emit;
    res.scalar     = (st == ST_VALID) ? cp : '0;
    res.byte_count = cnt;
    res.status     = st;
    res.null_char  = (st == ST_VALID) && (cp == '0);
  end

  // sequence state moves with each consumed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      left_r <= 2'd0;
      len_r  <= 3'd0;
    end else if (item_valid && advance) begin
      acc_r  <= acc_nxt;
      left_r <= left_nxt;
      len_r  <= len_nxt;
    end
  end

  // checks
  `ASSERT_IMP(a_err_zero_cp, clk, rst_n, res_valid && res.status != ST_VALID, res.scalar == '0)
  `ASSERT_IMP(a_null_valid, clk, rst_n, res_valid && res.null_char, res.status == ST_VALID)
  `ASSERT_IMP(a_open_len, clk, rst_n, left_r != 2'd0, len_r > {1'b0, left_r})
  `ASSERT_NEXT(a_close_idle, clk, rst_n, item_valid && advance && emit, left_r == 2'd0)

endmodule

`default_nettype wire

@@ rtl/u8d_out_stage.sv @@
// ----------------------------------------------------------------------------
// u8d_out_stage
// result register: holds one decoded word until the consumer takes it
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_out_stage (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 item_valid,
  input  wire logic                 res_valid,
  input  wire u8d_pkg::u8d_result_t res,
  output logic                      advance,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output u8d_pkg::u8d_result_t      out_res
);
  import u8d_pkg::*;

  logic        valid_r;
  u8d_result_t res_r;

  // slot free when empty or being drained
  assign advance = !valid_r || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= item_valid && res_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (advance && item_valid && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

@@ rtl/utf8_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// byte-wide utf-8 decoder giving code point, length and status per sequence
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  --------+-----------+-----------------------------------------------------
//  in      | sink      | in_valid, in_ready, in_data_byte, in_end_of_input
//  out     | source    | out_valid, out_ready, out_scalar, out_byte_count,
//          |           | out_status, out_null_char
//
// one byte per cycle sustained while out_ready is high; the result is
// registered as the byte closing its sequence leaves the input register.
// the rate is set by the sequence state register, updated once per byte.
// synchronous active-low reset clears the sequence state and both valid flags.
// out_ready low holds the result; in_ready drops once the input register is
// also full.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_decoder (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [u8d_pkg::BYTE_W-1:0]  in_data_byte,
  input  wire logic                        in_end_of_input,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [u8d_pkg::CP_W-1:0]         out_scalar,
  output logic [u8d_pkg::CNT_W-1:0]        out_byte_count,
  output logic [u8d_pkg::ST_W-1:0]         out_status,
  output logic                             out_null_char
);
  import u8d_pkg::*;

  logic              advance;
  logic              item_valid;
  logic [BYTE_W-1:0] item_byte;
  logic              item_last;
  logic              res_valid;
  u8d_result_t       res;
  u8d_result_t       out_res;

  // input register
  u8d_in_stage u_in (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_end_of_input (in_end_of_input),
    .advance         (advance),
    .item_valid      (item_valid),
    .item_byte       (item_byte),
    .item_last       (item_last)
  );

  // decode step
  u8d_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .advance    (advance),
    .item_byte  (item_byte),
    .item_last  (item_last),
    .res_valid  (res_valid),
    .res        (res)
  );

  // result register
  u8d_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .res_valid  (res_valid),
    .res        (res),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (out_res)
  );

  // result word onto ports
  assign out_scalar     = out_res.scalar;
  assign out_byte_count = out_res.byte_count;
  assign out_status     = out_res.status;
  assign out_null_char  = out_res.null_char;

endmodule

`default_nettype wire
